// ----- sv/spp_pkg.sv -----
// Shared constants and divider handshake types for the spectral peak picker.
package spp_pkg;

	// Spectrum length and derived index width
	localparam int BINS  = 1024;
	localparam int IDX_W = $clog2(BINS);

	// Fixed widths of the stream fields
	localparam int MAG_W  = 16;
	localparam int POS_W  = 18;
	localparam int FRAC_W = 8;

	// Offset divider: numerator 256*|n| + |d|, denominator 2*|d|
	localparam int DIV_NUM_W = 25;
	localparam int DIV_DEN_W = 19;
	localparam int QUOT_W    = 10;
	localparam int CNT_W     = $clog2(QUOT_W + 1);

	// One bin expressed in offset units
	localparam logic [QUOT_W-1:0] P8_LIMIT = QUOT_W'(256);

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic              sat;
		logic [QUOT_W-1:0] quot;
	} div_rsp_t;

endpackage

// ----- sv/spp_div.sv -----
// Iterative restoring divider for the interpolation offset, one quotient bit a cycle.
module spp_div (
	input  logic             clk,
	input  logic             arst_n,
	input  spp_pkg::div_req_t req,
	output spp_pkg::div_rsp_t rsp
);

	localparam int SH_W = spp_pkg::DIV_DEN_W + spp_pkg::QUOT_W;

	logic [spp_pkg::DIV_NUM_W-1:0] rem_q;
	logic [SH_W-1:0]               dv_q;
	logic [spp_pkg::CNT_W-1:0]     cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic                          sat_q;
	logic [spp_pkg::QUOT_W-1:0]    quot_q;
	logic [SH_W-1:0]               rem_ext;
	logic [SH_W-1:0]               diff;
	logic                          ge;

	// Shared compare and subtract
	assign rem_ext = SH_W'(rem_q);
	assign ge      = rem_ext >= dv_q;
	assign diff    = rem_ext - dv_q;

	// Sequence the steps: the first step flags an oversized quotient instead of giving a quotient bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= spp_pkg::CNT_W'(spp_pkg::QUOT_W);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Remainder, shifted divisor and quotient bits
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			dv_q  <= {req.den, {spp_pkg::QUOT_W{1'b0}}};
			sat_q <= 1'b0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= diff[spp_pkg::DIV_NUM_W-1:0];
			end
			if (cnt_q == spp_pkg::CNT_W'(spp_pkg::QUOT_W)) begin
				sat_q <= ge;
			end else begin
				quot_q <= {quot_q[spp_pkg::QUOT_W-2:0], ge};
			end
			dv_q <= dv_q >> 1;
		end
	end

	assign rsp.done = done_q;
	assign rsp.sat  = sat_q;
	assign rsp.quot = quot_q;

endmodule

// ----- sv/spectral_peak_picker_core.sv -----
// Spectral peak picker: peak test per centre bin and parabolic interpolation.
//
//  channel   dir  beat fields
//  s_*       in   tdata[15:0] magnitude, tlast last_bin
//  m_*       out  tuser peak_valid, tdata[17:0] bin_position, tdata[33:18] peak_height,
//                 tlast spectrum_end
//
//  A bin that yields no result leaves the sequencer idle; the slave side stays ready.
//  An end-of-spectrum beat without a peak waits in S_FIN for a free output register.
//  A peak bin goes through S_PREP, S_LOAD, the 11-step restoring divider for the offset
//  in S_DIV (skipped when the parabola's denominator is zero), S_MUL, S_HGT and S_FIN.
//  Reset clears the bin history, the bin index, the rising flag and the sequencer.
//  A stalled master side holds one finished result; the sequencer waits only when a
//  second result is ready before the first is taken.
module spectral_peak_picker_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] magnitude
	input  logic        s_tlast,   // last_bin
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [17:0] bin_position, [33:18] peak_height, [39:34] zero
	output logic        m_tlast,   // spectrum_end
	output logic        m_tuser    // [0] peak_valid
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_PREP = 7'b0000010,
		S_LOAD = 7'b0000100,
		S_DIV  = 7'b0001000,
		S_MUL  = 7'b0010000,
		S_HGT  = 7'b0100000,
		S_FIN  = 7'b1000000
	} state_t;

	localparam int MW = spp_pkg::MAG_W;
	localparam int IW = spp_pkg::IDX_W;
	localparam int PW = spp_pkg::POS_W;

	state_t state_q;

	logic signed [MW-1:0]  older_q;
	logic signed [MW-1:0]  newer_q;
	logic [IW-1:0]         idx_q;
	logic                  rising_q;

	logic signed [MW-1:0]  a_q;
	logic signed [MW-1:0]  b_q;
	logic signed [MW-1:0]  c_q;
	logic                  last_q;
	logic                  peak_q;
	logic [IW-1:0]         base_q;
	logic signed [MW:0]    n_q;
	logic signed [MW+2:0]  d_q;
	logic signed [9:0]     p8_q;
	logic signed [26:0]    prod_q;
	logic [17:0]           hr_q;
	logic                  hneg_q;

	logic                  m_valid_q;
	logic                  m_last_q;
	logic                  m_peak_q;
	logic [PW-1:0]         m_pos_q;
	logic [MW-1:0]         m_hgt_q;

	logic                  acc;
	logic signed [MW-1:0]  cur;
	logic                  is_last;
	logic                  center_ok;
	logic                  rise;
	logic                  peak;
	logic [MW:0]           nmag;
	logic [MW+2:0]         dmag;
	logic                  off_neg;
	logic [spp_pkg::QUOT_W-1:0] off_mag;
	logic signed [26:0]    prod_w;
	logic signed [27:0]    num_w;
	logic [27:0]           num_mag;
	logic [28:0]           num_rnd;
	logic [MW-1:0]         hgt_sat;
	logic [17:0]           hr_neg;
	logic [PW-1:0]         pos_w;
	logic                  out_free;

	spp_pkg::div_req_t div_req;
	spp_pkg::div_rsp_t div_rsp;

	// Peak test on the arriving beat
	assign s_tready  = state_q == S_IDLE;
	assign acc       = s_tvalid && s_tready;
	assign cur       = signed'(s_tdata[MW-1:0]);
	assign is_last   = s_tlast || (idx_q >= IW'(spp_pkg::BINS - 1));
	assign center_ok = idx_q >= IW'(2);
	assign rise      = center_ok && ((older_q < newer_q && newer_q <= cur) ||
	                                 (older_q <= newer_q && newer_q < cur));
	assign peak      = center_ok && !rise && ((older_q < newer_q && newer_q > cur) || rising_q);

	// Divider operands
	assign nmag = n_q[MW] ? (MW+1)'(-n_q) : (MW+1)'(n_q);
	assign dmag = d_q[MW+2] ? (MW+3)'(-d_q) : (MW+3)'(d_q);

	assign div_req.start = (state_q == S_LOAD) && (d_q != '0);
	assign div_req.num   = spp_pkg::DIV_NUM_W'({nmag[MW-1:0], 8'b0}) +
	                       spp_pkg::DIV_NUM_W'(dmag);
	assign div_req.den   = {dmag[MW+1:0], 1'b0};

	spp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Clamp the offset to one bin
	assign off_neg = n_q[MW] ^ d_q[MW+2];
	assign off_mag = (div_rsp.sat || div_rsp.quot > spp_pkg::P8_LIMIT) ?
	                 spp_pkg::P8_LIMIT : div_rsp.quot;

	// Height arithmetic
	assign prod_w  = 27'(n_q) * 27'(p8_q);
	assign num_w   = (28'(b_q) <<< 10) - 28'(prod_q);
	assign num_mag = num_w[27] ? 28'(-num_w) : 28'(num_w);
	assign num_rnd = 29'(num_mag) + 29'd512;
	assign hr_neg  = 18'(-hr_q);

	always_comb begin
		if (!hneg_q) begin
			hgt_sat = (hr_q > 18'd32767) ? 16'h7fff : hr_q[MW-1:0];
		end else begin
			hgt_sat = (hr_q > 18'd32768) ? 16'h8000 : hr_neg[MW-1:0];
		end
	end

	assign pos_w    = (PW'(base_q) << spp_pkg::FRAC_W) + PW'(p8_q);
	assign out_free = !m_valid_q || m_tready;

	// Sequencer and bin history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			older_q  <= '0;
			newer_q  <= '0;
			idx_q    <= '0;
			rising_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						older_q <= newer_q;
						newer_q <= cur;
						if (is_last) begin
							idx_q    <= '0;
							rising_q <= 1'b0;
						end else begin
							idx_q <= idx_q + 1'b1;
							if (rise) begin
								rising_q <= 1'b1;
							end else if (peak) begin
								rising_q <= 1'b0;
							end
						end
						if (peak) begin
							state_q <= S_PREP;
						end else if (is_last) begin
							state_q <= S_FIN;
						end
					end
				end
				S_PREP: state_q <= S_LOAD;
				S_LOAD: state_q <= (d_q != '0) ? S_DIV : S_MUL;
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_MUL;
					end
				end
				S_MUL:  state_q <= S_HGT;
				S_HGT:  state_q <= S_FIN;
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (acc) begin
			a_q    <= older_q;
			b_q    <= newer_q;
			c_q    <= cur;
			last_q <= is_last;
			peak_q <= peak;
			base_q <= idx_q - 1'b1;
		end
		if (state_q == S_PREP) begin
			n_q <= (MW+1)'(a_q) - (MW+1)'(c_q);
			d_q <= (MW+3)'(a_q) - ((MW+3)'(b_q) <<< 1) + (MW+3)'(c_q);
		end
		if (state_q == S_LOAD && d_q == '0) begin
			p8_q <= '0;
		end
		if (state_q == S_DIV && div_rsp.done) begin
			p8_q <= off_neg ? -signed'(off_mag) : signed'(off_mag);
		end
		if (state_q == S_MUL) begin
			prod_q <= prod_w;
		end
		if (state_q == S_HGT) begin
			hr_q   <= num_rnd[27:10];
			hneg_q <= num_w[27];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && out_free) begin
			m_last_q <= last_q;
			m_peak_q <= peak_q;
			m_pos_q  <= peak_q ? pos_w : '0;
			m_hgt_q  <= peak_q ? hgt_sat : '0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tlast  = m_last_q;
	assign m_tuser  = m_peak_q;
	assign m_tdata  = {6'b0, m_hgt_q, m_pos_q};

	// Divider only finishes while the sequencer waits for it
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == S_DIV)
		else $error("divider finished outside the divide step");

	// A result without a peak is only the end-of-spectrum marker
	a_nopeak_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tlast && m_tdata == '0))
		else $error("result without peak carries payload or lacks end flag");

	// Offset stays within one bin
	a_offset_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL) |-> (p8_q <= 10'sd256 && p8_q >= -10'sd256))
		else $error("interpolation offset beyond one bin");

	// Bin index restarts after the spectrum's last bin
	a_index_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && is_last) |=> (idx_q == '0 && !rising_q))
		else $error("bin index or rising flag not cleared after last bin");

endmodule
